/* rtl/rotation_matrix_to_quaternion_macros.svh */
// Assertion macros for the rotation matrix to quaternion RTL.
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define RMQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rmq_pkg.sv */
// Shared types and constants of the rotation matrix to quaternion pipeline.
package rmq_pkg;

   // Field and datapath widths.
   localparam int ENTRY_W     = 16;
   localparam int TRACE_W     = 18;
   localparam int RADS_W      = 19;
   localparam int RAD_W       = 17;
   localparam int D_W         = 17;
   localparam int SQRT_SHIFT  = 28;
   localparam int SQRT_STAGES = 23;
   localparam int ROOT_W      = SQRT_STAGES;
   localparam int REM_W       = ROOT_W + 1;
   localparam int QUO_W       = 15;
   localparam int DIV_SHIFT   = 20;
   localparam int NUM_W       = 1 + D_W + DIV_SHIFT;
   localparam int DIV_STAGES  = QUO_W + 1;
   localparam int LANES       = 3;
   localparam int ROUND_BIAS  = 128;
   localparam int OWN_SHIFT   = 8;
   localparam int Q14_ONE     = 16384;

   // Which component takes S/4.
   typedef enum logic [1:0] {
      OWN_X = 2'd0,
      OWN_Y = 2'd1,
      OWN_Z = 2'd2,
      OWN_W = 2'd3
   } rmq_own_type;

   // Data that rides alongside the square root and the divider.
   typedef struct packed {
      logic [LANES-1:0][D_W-1:0] d;
      rmq_own_type               own;
      logic                      degen;
   } rmq_side_type;

endpackage

/* rtl/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
module rmq_sqrt
   import rmq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  rmq_side_type      in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output rmq_side_type      out_side
);

   logic              valid_ff [SQRT_STAGES];
   logic [RAD_W-1:0]  rad_ff   [SQRT_STAGES];
   logic [ROOT_W-1:0] res_ff   [SQRT_STAGES];
   logic [REM_W-1:0]  rem_ff   [SQRT_STAGES];
   rmq_side_type      side_ff  [SQRT_STAGES];

   genvar k;
   for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic                     prev_valid;
      logic [RAD_W-1:0]         prev_rad;
      logic [ROOT_W-1:0]        prev_res;
      logic [REM_W-1:0]         prev_rem;
      rmq_side_type             prev_side;
      logic [2*SQRT_STAGES-1:0] radicand;
      logic [1:0]               pair;
      logic [REM_W+1:0]         rem_sh;
      logic [REM_W+1:0]         trial;
      logic [REM_W+1:0]         diff;
      logic                     take;
      logic [ROOT_W-1:0]        res_in;
      logic [REM_W-1:0]         rem_in;

      // The first stage starts from an empty root and remainder.
      if (k == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rad   = in_rad;
         assign prev_res   = '0;
         assign prev_rem   = '0;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[k-1];
         assign prev_rad   = rad_ff[k-1];
         assign prev_res   = res_ff[k-1];
         assign prev_rem   = rem_ff[k-1];
         assign prev_side  = side_ff[k-1];
      end

      // Bring down the next bit pair and try to subtract 4*root + 1.
      assign radicand = {{(2*SQRT_STAGES-RAD_W-SQRT_SHIFT){1'b0}}, prev_rad,
                         {SQRT_SHIFT{1'b0}}};
      assign pair   = radicand[2*SQRT_STAGES-1-2*k -: 2];
      assign rem_sh = {prev_rem, pair};
      assign trial  = {1'b0, prev_res, 2'b01};
      assign diff   = rem_sh - trial;
      assign take   = (rem_sh >= trial);
      assign rem_in = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      assign res_in = {prev_res[ROOT_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= prev_rad;
            res_ff[k]  <= res_in;
            rem_ff[k]  <= rem_in;
            side_ff[k] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = res_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

/* rtl/rmq_div.sv */
// Pipelined three-lane restoring divider for the off-diagonal terms.
module rmq_div
   import rmq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [ROOT_W-1:0]           in_root,
   input  rmq_side_type                in_side,
   output logic                        out_valid,
   output logic [ROOT_W-1:0]           out_root,
   output rmq_side_type                out_side,
   output logic [LANES-1:0][QUO_W-1:0] out_quo,
   output logic [LANES-1:0]            out_ovf
);

   logic                        valid_ff [DIV_STAGES];
   logic [ROOT_W-1:0]           root_ff  [DIV_STAGES];
   rmq_side_type                side_ff  [DIV_STAGES];
   logic [LANES-1:0][NUM_W-1:0] rem_ff   [DIV_STAGES];
   logic [LANES-1:0][QUO_W-1:0] quo_ff   [DIV_STAGES];
   logic [LANES-1:0]            ovf_ff   [DIV_STAGES];

   genvar k;
   genvar l;
   for (k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic                        prev_valid;
      logic [ROOT_W-1:0]           prev_root;
      rmq_side_type                prev_side;
      logic [LANES-1:0][NUM_W-1:0] rem_in;
      logic [LANES-1:0][QUO_W-1:0] quo_in;
      logic [LANES-1:0]            ovf_in;

      if (k == 0) begin : g_setup
         assign prev_valid = in_valid;
         assign prev_root  = in_root;
         assign prev_side  = in_side;

         // Rounded dividend |d| * 2^20 + root/2, and the check for a quotient
         // that cannot fit the saturated range.
         for (l = 0; l < LANES; l++) begin : g_lane
            logic [D_W-1:0]   mag;
            logic [NUM_W-1:0] num;
            assign mag = prev_side.d[l][D_W-1] ? (~prev_side.d[l] + 1'b1)
                                                : prev_side.d[l];
            assign num = {1'b0, mag, {DIV_SHIFT{1'b0}}}
                       + NUM_W'(prev_root[ROOT_W-1:1]);
            assign rem_in[l] = num;
            assign quo_in[l] = '0;
            assign ovf_in[l] = (num >= (NUM_W'(prev_root) << QUO_W));
         end
      end else begin : g_iter
         localparam int J = QUO_W - k;

         assign prev_valid = valid_ff[k-1];
         assign prev_root  = root_ff[k-1];
         assign prev_side  = side_ff[k-1];

         // One quotient bit per lane in this stage.
         for (l = 0; l < LANES; l++) begin : g_lane
            logic [NUM_W-1:0] dsr;
            logic             take;
            assign dsr  = NUM_W'(prev_root) << J;
            assign take = (rem_ff[k-1][l] >= dsr);
            assign rem_in[l] = take ? (rem_ff[k-1][l] - dsr) : rem_ff[k-1][l];
            always_comb begin
               quo_in[l]    = quo_ff[k-1][l];
               quo_in[l][J] = take;
            end
            assign ovf_in[l] = ovf_ff[k-1][l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k] <= prev_root;
            side_ff[k] <= prev_side;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            ovf_ff[k]  <= ovf_in;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_root  = root_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];
   assign out_quo   = quo_ff[DIV_STAGES-1];
   assign out_ovf   = ovf_ff[DIV_STAGES-1];

endmodule

/* rtl/rotation_matrix_to_quaternion.sv */
// Top level of the rotation matrix to quaternion converter.
// Converts one 3x3 Q2.14 rotation matrix per request into a Q2.14 quaternion
// by Shepperd's method. The pipeline takes a new request every cycle unless
// it is held, and registers each request through these steps: a front
// register after branch selection and the radicand, the square root one bit
// per stage, the divider for the three off-diagonal terms in parallel, and
// rounding and saturation into the output register. The whole pipeline
// holds while a result sits on the output and rsp_stall is high.
// A radicand at or below zero gives an all-zero quaternion with rsp_degenerate set.
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion
   import rmq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [ENTRY_W-1:0] req_m00,
   input  logic signed [ENTRY_W-1:0] req_m01,
   input  logic signed [ENTRY_W-1:0] req_m02,
   input  logic signed [ENTRY_W-1:0] req_m10,
   input  logic signed [ENTRY_W-1:0] req_m11,
   input  logic signed [ENTRY_W-1:0] req_m12,
   input  logic signed [ENTRY_W-1:0] req_m20,
   input  logic signed [ENTRY_W-1:0] req_m21,
   input  logic signed [ENTRY_W-1:0] req_m22,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ENTRY_W-1:0] rsp_quat_x,
   output logic signed [ENTRY_W-1:0] rsp_quat_y,
   output logic signed [ENTRY_W-1:0] rsp_quat_z,
   output logic signed [ENTRY_W-1:0] rsp_quat_w,
   output logic                      rsp_degenerate
);

   logic                      adv;
   logic signed [TRACE_W-1:0] trace;
   logic signed [RADS_W-1:0]  rad_s;
   logic signed [D_W-1:0]     d0;
   logic signed [D_W-1:0]     d1;
   logic signed [D_W-1:0]     d2;
   rmq_own_type               own;
   rmq_side_type              side_in;
   logic [RAD_W-1:0]          rad_in;
   logic                      front_valid_ff;
   logic [RAD_W-1:0]          rad_ff;
   rmq_side_type              side_ff;
   logic                      sq_valid;
   logic [ROOT_W-1:0]         sq_root;
   rmq_side_type              sq_side;
   logic                      dv_valid;
   logic [ROOT_W-1:0]         dv_root;
   rmq_side_type              dv_side;
   logic [LANES-1:0][QUO_W-1:0] dv_quo;
   logic [LANES-1:0]          dv_ovf;
   logic [ROOT_W:0]           own_sum;
   logic signed [ENTRY_W-1:0] own_val;
   logic signed [ENTRY_W-1:0] lane_val [LANES];
   logic signed [ENTRY_W-1:0] qx_in;
   logic signed [ENTRY_W-1:0] qy_in;
   logic signed [ENTRY_W-1:0] qz_in;
   logic signed [ENTRY_W-1:0] qw_in;
   logic                      rsp_valid_ff;
   logic signed [ENTRY_W-1:0] qx_ff;
   logic signed [ENTRY_W-1:0] qy_ff;
   logic signed [ENTRY_W-1:0] qz_ff;
   logic signed [ENTRY_W-1:0] qw_ff;
   logic                      degen_ff;
   rmq_own_type               own_ff;
   logic                      degen_shown;
   logic                      quat_zero;
   logic                      w_chosen;

   // The pipeline moves unless a finished result is being held.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Branch selection, radicand and off-diagonal sums or differences.
   assign trace = TRACE_W'(req_m00) + TRACE_W'(req_m11) + TRACE_W'(req_m22);

   always_comb begin
      if (trace > 0) begin
         own   = OWN_W;
         rad_s = RADS_W'(Q14_ONE) + RADS_W'(trace);
         d0    = D_W'(req_m21) - D_W'(req_m12);
         d1    = D_W'(req_m02) - D_W'(req_m20);
         d2    = D_W'(req_m10) - D_W'(req_m01);
      end else if (req_m00 > req_m11 && req_m00 > req_m22) begin
         own   = OWN_X;
         rad_s = RADS_W'(Q14_ONE) + RADS_W'(req_m00) - RADS_W'(req_m11)
               - RADS_W'(req_m22);
         d0    = D_W'(req_m01) + D_W'(req_m10);
         d1    = D_W'(req_m02) + D_W'(req_m20);
         d2    = D_W'(req_m21) - D_W'(req_m12);
      end else if (req_m11 > req_m22) begin
         own   = OWN_Y;
         rad_s = RADS_W'(Q14_ONE) + RADS_W'(req_m11) - RADS_W'(req_m00)
               - RADS_W'(req_m22);
         d0    = D_W'(req_m01) + D_W'(req_m10);
         d1    = D_W'(req_m12) + D_W'(req_m21);
         d2    = D_W'(req_m02) - D_W'(req_m20);
      end else begin
         own   = OWN_Z;
         rad_s = RADS_W'(Q14_ONE) + RADS_W'(req_m22) - RADS_W'(req_m00)
               - RADS_W'(req_m11);
         d0    = D_W'(req_m02) + D_W'(req_m20);
         d1    = D_W'(req_m12) + D_W'(req_m21);
         d2    = D_W'(req_m10) - D_W'(req_m01);
      end
   end

   // A radicand at or below zero is clamped and marks the result degenerate.
   assign rad_in        = (rad_s <= 0) ? '0 : rad_s[RAD_W-1:0];
   assign side_in.d[0]  = d0;
   assign side_in.d[1]  = d1;
   assign side_in.d[2]  = d2;
   assign side_in.own   = own;
   assign side_in.degen = (rad_s <= 0);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (adv) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff  <= rad_in;
         side_ff <= side_in;
      end
   end

   rmq_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid_ff),
      .in_rad    (rad_ff),
      .in_side   (side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   rmq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_root  (dv_root),
      .out_side  (dv_side),
      .out_quo   (dv_quo),
      .out_ovf   (dv_ovf)
   );

   // Own component is S/4, rounded half up.
   assign own_sum = {1'b0, dv_root} + (ROOT_W+1)'(ROUND_BIAS);
   assign own_val = own_sum[OWN_SHIFT +: ENTRY_W];

   // Sign and saturation of each divided term.
   genvar l;
   for (l = 0; l < LANES; l++) begin : g_lane
      logic neg;
      assign neg = dv_side.d[l][D_W-1];
      always_comb begin
         if (dv_ovf[l]) begin
            lane_val[l] = neg ? ENTRY_W'(-32768) : ENTRY_W'(32767);
         end else if (neg) begin
            lane_val[l] = -{1'b0, dv_quo[l]};
         end else begin
            lane_val[l] = {1'b0, dv_quo[l]};
         end
      end
   end

   // Place the own component and fill the others in lane order.
   always_comb begin
      qx_in = lane_val[0];
      qy_in = lane_val[1];
      qz_in = lane_val[2];
      qw_in = lane_val[2];
      unique case (dv_side.own)
         OWN_X: begin
            qx_in = own_val;
            qy_in = lane_val[0];
            qz_in = lane_val[1];
         end
         OWN_Y: begin
            qy_in = own_val;
            qz_in = lane_val[1];
         end
         OWN_Z: begin
            qz_in = own_val;
         end
         OWN_W: begin
            qz_in = lane_val[2];
            qw_in = own_val;
         end
         default: begin
            qw_in = lane_val[2];
         end
      endcase
      if (dv_side.degen) begin
         qx_in = '0;
         qy_in = '0;
         qz_in = '0;
         qw_in = '0;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
         qz_ff    <= qz_in;
         qw_ff    <= qw_in;
         degen_ff <= dv_side.degen;
         own_ff   <= dv_side.own;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_quat_x     = qx_ff;
   assign rsp_quat_y     = qy_ff;
   assign rsp_quat_z     = qz_ff;
   assign rsp_quat_w     = qw_ff;
   assign rsp_degenerate = degen_ff;

   // Terms for the output checks.
   assign degen_shown = rsp_valid_ff && degen_ff;
   assign quat_zero   = (qx_ff == 0) && (qy_ff == 0) && (qz_ff == 0) && (qw_ff == 0);
   assign w_chosen    = rsp_valid_ff && !degen_ff && (own_ff == OWN_W);

   // A degenerate result carries an all-zero quaternion.
   `RMQ_ASSERT_NOW(a_degen_zero, degen_shown, quat_zero, "degenerate result with nonzero quaternion")
   // A regular result has a strictly positive scalar part when w is chosen.
   `RMQ_ASSERT_NOW(a_own_pos, w_chosen, qw_ff > 0, "trace branch gave a non-positive w")
   // While the pipeline holds, the first stage keeps its request.
   `RMQ_ASSERT_NEXT(a_front_hold, !adv, $stable(front_valid_ff), "first stage changed while held")

endmodule
